FILE: sv/cs_pkg.sv
// ----------------------------------------------------------------------------
// cs_pkg
// Shared types, constants and width helpers for the cosine similarity block.
// ----------------------------------------------------------------------------
`default_nettype none

package cs_pkg;

    localparam int ELEM_W      = 16;
    localparam int COS_W       = 16;
    localparam int PROD_W      = 2 * ELEM_W;
    localparam int Q_SHIFT     = 15;
    localparam int MAX_LEN_DEF = 256;

    // Saturation limits of the Q1.15 result, as magnitudes
    localparam int COS_POS_LIM = 32767;
    localparam int COS_NEG_LIM = 32768;

    localparam logic [COS_W-1:0] COS_MAX  = 16'h7FFF;
    localparam logic [COS_W-1:0] COS_MIN  = 16'h8000;
    localparam logic [COS_W-1:0] COS_ZERO = 16'h0000;

    typedef logic signed [ELEM_W-1:0] t_elem;
    typedef logic        [COS_W-1:0]  t_cos;

    // Width of a sum of squares over max_len pairs
    function automatic int sq_width(input int max_len);
        return PROD_W - 1 + $clog2(max_len + 1);
    endfunction

endpackage

`default_nettype wire

FILE: sv/cosine_similarity.sv
// ----------------------------------------------------------------------------
// cosine_similarity
// Streams element pairs, accumulates dot product and sums of squares, and
// hands each finished run to cs_finish for roots, divide and saturation.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------
//  input   | in        | i_valid / o_ready  | i_elem_a, i_elem_b, i_last
//  result  | out       | o_valid / i_ready  | o_cosine, o_zero_norm, o_too_long
//
//  An accumulated item is accepted, then takes four steps: a*b, a*a and b*b
//  through the single 16x16 multiplier, then the final add. A pair past
//  MAX_LEN is dropped when accepted and flags the run as too long. A run
//  is finished in cs_finish by the bit-serial subtract unit; the next run
//  accumulates meanwhile. A last item waits while the previous run is still
//  in cs_finish, which holds a finished result until its output is free.
//  Synchronous active-low reset clears the accumulators; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module cosine_similarity #(
    parameter int MAX_LEN = cs_pkg::MAX_LEN_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output      logic          o_ready,
    input  wire cs_pkg::t_elem i_elem_a,
    input  wire cs_pkg::t_elem i_elem_b,
    input  wire logic          i_last,
    output      logic          o_valid,
    input  wire logic          i_ready,
    output      cs_pkg::t_cos  o_cosine,
    output      logic          o_zero_norm,
    output      logic          o_too_long
);
    import cs_pkg::*;

    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int SQ_W  = sq_width(MAX_LEN);
    localparam int DOT_W = SQ_W + 1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_AB   = 6'b000010,
        S_AA   = 6'b000100,
        S_BB   = 6'b001000,
        S_ADD  = 6'b010000,
        S_FIN  = 6'b100000
    } t_acc_state;

    t_acc_state               r_state, n_state;
    t_elem                    r_a, n_a;
    t_elem                    r_b, n_b;
    logic                     r_last, n_last;
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic signed [DOT_W-1:0]  r_dot, n_dot;
    logic        [SQ_W-1:0]   r_na, n_na;
    logic        [SQ_W-1:0]   r_nb, n_nb;
    logic        [CNT_W-1:0]  r_count, n_count;
    logic                     r_over, n_over;

    t_elem                    w_mul_x, w_mul_y;
    logic signed [PROD_W-1:0] w_prod;
    logic                     w_start;
    logic                     w_fin_busy;

    // Shared multiplier, operands steered by the sequencer
    assign w_mul_x = (r_state == S_BB) ? r_b : r_a;
    assign w_mul_y = (r_state == S_AA) ? r_a : r_b;
    assign w_prod  = w_mul_x * w_mul_y;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_a     = r_a;
        n_b     = r_b;
        n_last  = r_last;
        n_prod  = r_prod;
        n_dot   = r_dot;
        n_na    = r_na;
        n_nb    = r_nb;
        n_count = r_count;
        n_over  = r_over;
        w_start = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_a    = i_elem_a;
                    n_b    = i_elem_b;
                    n_last = i_last;
                    if (r_count < CNT_W'(MAX_LEN)) begin
                        n_count = r_count + 1'b1;
                        n_state = S_AB;
                    end else begin
                        // Drop the pair, remember the run ran long
                        n_over  = 1'b1;
                        n_state = i_last ? S_FIN : S_IDLE;
                    end
                end
            end
            S_AB: begin
                n_prod  = w_prod;
                n_state = S_AA;
            end
            S_AA: begin
                n_dot   = r_dot + DOT_W'(r_prod);
                n_prod  = w_prod;
                n_state = S_BB;
            end
            S_BB: begin
                n_na    = r_na + SQ_W'(r_prod[PROD_W-2:0]);
                n_prod  = w_prod;
                n_state = S_ADD;
            end
            S_ADD: begin
                n_nb    = r_nb + SQ_W'(r_prod[PROD_W-2:0]);
                n_state = r_last ? S_FIN : S_IDLE;
            end
            S_FIN: begin
                if (!w_fin_busy) begin
                    w_start = 1'b1;
                    n_dot   = '0;
                    n_na    = '0;
                    n_nb    = '0;
                    n_count = '0;
                    n_over  = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dot   <= '0;
            r_na    <= '0;
            r_nb    <= '0;
            r_count <= '0;
            r_over  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dot   <= n_dot;
            r_na    <= n_na;
            r_nb    <= n_nb;
            r_count <= n_count;
            r_over  <= n_over;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a    <= n_a;
        r_b    <= n_b;
        r_last <= n_last;
        r_prod <= n_prod;
    end

    cs_finish #(
        .MAX_LEN (MAX_LEN)
    ) u_finish (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_dot       (r_dot),
        .i_na        (r_na),
        .i_nb        (r_nb),
        .i_too_long  (r_over),
        .o_busy      (w_fin_busy),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_cosine    (o_cosine),
        .o_zero_norm (o_zero_norm),
        .o_too_long  (o_too_long)
    );

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_LEN))
        else $error("pair count past MAX_LEN");

    a_over_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_over |-> (r_count == CNT_W'(MAX_LEN)))
        else $error("overflow flag without a full run");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> w_fin_busy)
        else $error("finisher did not take the run");

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> (r_count == '0) && (r_na == '0) && (r_nb == '0))
        else $error("accumulators not cleared after hand-off");

endmodule

`default_nettype wire

FILE: sv/cs_finish.sv
// ----------------------------------------------------------------------------
// cs_finish
// Final stage: two square roots, norm product, scaled divide and Q1.15
// saturation; the roots and the divide share one compare-subtract unit.
// ----------------------------------------------------------------------------
`default_nettype none

module cs_finish #(
    parameter  int MAX_LEN = cs_pkg::MAX_LEN_DEF,
    localparam int SQ_W    = cs_pkg::sq_width(MAX_LEN),
    localparam int DOT_W   = SQ_W + 1
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic signed [DOT_W-1:0] i_dot,
    input  wire logic        [SQ_W-1:0]  i_na,
    input  wire logic        [SQ_W-1:0]  i_nb,
    input  wire logic                    i_too_long,
    output      logic                    o_busy,
    output      logic                    o_valid,
    input  wire logic                    i_ready,
    output      cs_pkg::t_cos            o_cosine,
    output      logic                    o_zero_norm,
    output      logic                    o_too_long
);
    import cs_pkg::*;

    localparam int ROOT_W = (SQ_W + 1) / 2;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int DEN_W  = RAD_W;
    localparam int AW     = DEN_W + 1;
    localparam int NUM_W  = SQ_W + Q_SHIFT;
    localparam int PAD_W  = NUM_W - RAD_W;
    localparam int STEP_W = $clog2(NUM_W + 1);

    typedef enum logic [5:0] {
        F_IDLE = 6'b000001,
        F_SQA  = 6'b000010,
        F_SQB  = 6'b000100,
        F_MUL  = 6'b001000,
        F_DIV  = 6'b010000,
        F_DONE = 6'b100000
    } t_fin_state;

    t_fin_state         r_state, n_state;
    logic [STEP_W-1:0]  r_step, n_step;
    logic [AW-1:0]      r_rem, n_rem;
    logic [NUM_W-1:0]   r_work, n_work;
    logic [ROOT_W-1:0]  r_root_a, n_root_a;
    logic [ROOT_W-1:0]  r_root_b, n_root_b;
    logic [DEN_W-1:0]   r_den, n_den;
    logic [SQ_W-1:0]    r_nb, n_nb;
    logic [SQ_W-1:0]    r_mag, n_mag;
    logic               r_neg, n_neg;
    logic               r_zero, n_zero;
    logic               r_long, n_long;
    logic               r_out_valid, n_out_valid;
    t_cos               r_cos, n_cos;
    logic               r_out_zero, n_out_zero;
    logic               r_out_long, n_out_long;

    logic [DOT_W-1:0]   w_abs;
    logic [ROOT_W-1:0]  w_sq_root;
    logic [AW-1:0]      w_alu_a, w_alu_b;
    logic [AW:0]        w_diff;
    logic               w_borrow;
    t_cos               w_sat;
    t_cos               w_neg_q;

    assign w_abs = i_dot[DOT_W-1] ? (~i_dot + 1'b1) : i_dot;

    // Shared compare-subtract unit: root digit trial or divide step
    assign w_sq_root = (r_state == F_SQB) ? r_root_b : r_root_a;
    always_comb begin
        if (r_state == F_DIV) begin
            w_alu_a = {r_rem[AW-2:0], r_work[NUM_W-1]};
            w_alu_b = AW'(r_den);
        end else begin
            w_alu_a = {r_rem[AW-3:0], r_work[NUM_W-1 -: 2]};
            w_alu_b = AW'({w_sq_root, 2'b01});
        end
    end
    assign w_diff   = {1'b0, w_alu_a} - {1'b0, w_alu_b};
    assign w_borrow = w_diff[AW];

    // Saturate the quotient held in r_work to Q1.15
    assign w_neg_q = COS_ZERO - r_work[COS_W-1:0];
    always_comb begin
        if (r_zero) begin
            w_sat = COS_ZERO;
        end else if (r_neg) begin
            w_sat = (r_work > NUM_W'(COS_NEG_LIM)) ? COS_MIN : w_neg_q;
        end else begin
            w_sat = (r_work > NUM_W'(COS_POS_LIM)) ? COS_MAX : r_work[COS_W-1:0];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_rem       = r_rem;
        n_work      = r_work;
        n_root_a    = r_root_a;
        n_root_b    = r_root_b;
        n_den       = r_den;
        n_nb        = r_nb;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_zero      = r_zero;
        n_long      = r_long;
        n_cos       = r_cos;
        n_out_zero  = r_out_zero;
        n_out_long  = r_out_long;
        n_out_valid = (r_out_valid && i_ready) ? 1'b0 : r_out_valid;

        unique case (r_state) inside
            F_IDLE: begin
                if (i_start) begin
                    n_nb     = i_nb;
                    n_mag    = w_abs[SQ_W-1:0];
                    n_neg    = i_dot[DOT_W-1];
                    n_long   = i_too_long;
                    n_zero   = (i_na == '0) || (i_nb == '0);
                    n_work   = {RAD_W'(i_na), {PAD_W{1'b0}}};
                    n_rem    = '0;
                    n_root_a = '0;
                    n_root_b = '0;
                    n_step   = '0;
                    n_state  = n_zero ? F_DONE : F_SQA;
                end
            end
            F_SQA, F_SQB: begin
                if (!w_borrow) begin
                    n_rem = w_diff[AW-1:0];
                end else begin
                    n_rem = w_alu_a;
                end
                if (r_state == F_SQA) begin
                    n_root_a = {r_root_a[ROOT_W-2:0], ~w_borrow};
                end else begin
                    n_root_b = {r_root_b[ROOT_W-2:0], ~w_borrow};
                end
                n_work = {r_work[NUM_W-3:0], 2'b00};
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(ROOT_W - 1)) begin
                    n_step = '0;
                    n_rem  = '0;
                    if (r_state == F_SQA) begin
                        n_work  = {RAD_W'(r_nb), {PAD_W{1'b0}}};
                        n_state = F_SQB;
                    end else begin
                        n_state = F_MUL;
                    end
                end
            end
            F_MUL: begin
                n_den   = r_root_a * r_root_b;
                n_work  = {r_mag, {Q_SHIFT{1'b0}}};
                n_rem   = '0;
                n_step  = '0;
                n_state = F_DIV;
            end
            F_DIV: begin
                n_rem  = w_borrow ? w_alu_a : w_diff[AW-1:0];
                n_work = {r_work[NUM_W-2:0], ~w_borrow};
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(NUM_W - 1)) begin
                    n_step  = '0;
                    n_state = F_DONE;
                end
            end
            F_DONE: begin
                // Hold until the output register is free
                if (!r_out_valid || i_ready) begin
                    n_cos       = w_sat;
                    n_out_zero  = r_zero;
                    n_out_long  = r_long;
                    n_out_valid = 1'b1;
                    n_state     = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= F_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem      <= n_rem;
        r_work     <= n_work;
        r_root_a   <= n_root_a;
        r_root_b   <= n_root_b;
        r_den      <= n_den;
        r_nb       <= n_nb;
        r_mag      <= n_mag;
        r_neg      <= n_neg;
        r_zero     <= n_zero;
        r_long     <= n_long;
        r_cos      <= n_cos;
        r_out_zero <= n_out_zero;
        r_out_long <= n_out_long;
    end

    assign o_busy      = (r_state != F_IDLE);
    assign o_valid     = r_out_valid;
    assign o_cosine    = r_cos;
    assign o_zero_norm = r_out_zero;
    assign o_too_long  = r_out_long;

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step < STEP_W'(NUM_W))
        else $error("step counter ran past the divide length");

    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == F_DONE)
        else $error("result loaded outside the done state");

    a_zero_gives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_zero) |-> (r_cos == COS_ZERO))
        else $error("zero norm result with nonzero cosine");

    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == F_IDLE))
        else $error("start while a result is still in work");

endmodule

`default_nettype wire
